[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by bce_muldiv and bce_dp.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define BCE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// condition must never be seen outside reset
`define BCE_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`endif

[rtl/core/bce_pkg.sv]
// ---------------------------------------------------------------------------
// bce_pkg
// Types, constants and codes of the betweenness centrality engine.
// ---------------------------------------------------------------------------
package bce_pkg;

  localparam int MaxVertices    = 1024;
  localparam int MaxEdgeEntries = 8192;
  localparam int FractionBits   = 16;

  localparam int VIDX_W  = 10;
  localparam int VCNT_W  = 11;
  localparam int EIDX_W  = 13;
  localparam int ROW_W   = 14;
  localparam int NB_W    = VIDX_W + 1;
  localparam int DIST_W  = 11;
  localparam int PC_W    = 64;
  localparam int DEP_W   = FractionBits + 10;
  localparam int SCORE_W = FractionBits + 20;
  localparam int MB_W    = DEP_W + 1;
  localparam int HALF_W  = PC_W / 2;
  localparam int MUL_W   = HALF_W + MB_W;
  localparam int PROD_W  = PC_W + MB_W;
  localparam int MD_CNT_W = $clog2(PROD_W);

  localparam logic [DIST_W-1:0] DIST_UNV = '1;
  localparam logic [DEP_W-1:0]  DEP_MAX  = '1;
  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

  localparam logic [1:0] FUNC_ROW  = 2'd0;
  localparam logic [1:0] FUNC_COL  = 2'd1;
  localparam logic [1:0] FUNC_RUN  = 2'd2;
  localparam logic [1:0] FUNC_READ = 2'd3;

  localparam logic KIND_DONE  = 1'b0;
  localparam logic KIND_SCORE = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [13:0] index;
    logic [13:0] value;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [9:0]  vertex;
    logic [35:0] score;
    logic        overflow;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_INIT,
    OP_SEED,
    OP_B_HEAD,
    OP_V1,
    OP_V2,
    OP_V3,
    OP_EDGE,
    OP_E1,
    OP_B_E2,
    OP_R_TOP,
    OP_R_E2,
    OP_R_E3,
    OP_R_CENT,
    OP_R_C2,
    OP_NEXT,
    OP_DONE,
    OP_READ,
    OP_READ_OUT
  } op_e;

  typedef enum logic [4:0] {
    ST_BOOT,
    ST_IDLE,
    ST_CLEAR,
    ST_SRC,
    ST_INIT,
    ST_SEED,
    ST_B_HEAD,
    ST_B_V1,
    ST_B_V2,
    ST_B_V3,
    ST_B_EDGE,
    ST_B_E1,
    ST_B_E2,
    ST_R_TOP,
    ST_R_W1,
    ST_R_W2,
    ST_R_W3,
    ST_R_EDGE,
    ST_R_E1,
    ST_R_E2,
    ST_R_MD,
    ST_R_E3,
    ST_R_CENT,
    ST_R_C2,
    ST_NEXT,
    ST_DONE,
    ST_READ,
    ST_READ_OUT
  } st_e;

  typedef enum logic [2:0] {
    MD_IDLE,
    MD_MUL_LO,
    MD_MUL_HI,
    MD_SUM,
    MD_DIV
  } md_state_e;

  typedef struct packed {
    op_e  op;
    logic accept;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic init_last;
    logic src_lt_n;
    logic head_lt_tail;
    logic j_lt_hi;
    logic nb_bad;
    logic k_nz;
    logic cur_is_src;
    logic dep_pass;
    logic md_done;
    logic out_free;
  } stat_t;

endpackage

[rtl/core/bce_muldiv.sv]
// ---------------------------------------------------------------------------
// bce_muldiv
// Saturating floor(a * b / c), zero when c is zero: split multiply, then bit-serial division.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bce_muldiv (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bce_pkg::PC_W-1:0]   a_i,
  input  logic [bce_pkg::MB_W-1:0]   b_i,
  input  logic [bce_pkg::PC_W-1:0]   c_i,
  output logic                       done_o,
  output logic [bce_pkg::DEP_W-1:0]  q_o
);
  import bce_pkg::*;

  md_state_e state_q, state_d;
  logic [MD_CNT_W-1:0] cnt_q;
  logic                done_q;
  logic                sat_q;

  logic [PC_W-1:0]   a_q, c_q, rem_q;
  logic [MB_W-1:0]   b_q;
  logic [MUL_W-1:0]  mul_q, lo_q;
  logic [PROD_W-1:0] prod_q;
  logic [DEP_W-1:0]  quo_q;

  logic [HALF_W-1:0] mul_a;
  logic [PC_W:0]     trial, diff;
  logic              ge;

  assign mul_a = (state_q == MD_MUL_LO) ? a_q[HALF_W-1:0] : a_q[PC_W-1:HALF_W];
  assign trial = {rem_q, prod_q[PROD_W-1]};
  assign ge    = trial >= {1'b0, c_q};
  assign diff  = trial - {1'b0, c_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      MD_IDLE:   if (start_i) state_d = MD_MUL_LO;
      MD_MUL_LO: state_d = MD_MUL_HI;
      MD_MUL_HI: state_d = MD_SUM;
      MD_SUM:    state_d = MD_DIV;
      MD_DIV:    if (cnt_q == '0) state_d = MD_IDLE;
      default:   state_d = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      sat_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == MD_DIV) && (cnt_q == '0);
      if (state_q == MD_SUM) begin
        cnt_q <= MD_CNT_W'(PROD_W - 1);
        sat_q <= 1'b0;
      end else if (state_q == MD_DIV) begin
        cnt_q <= cnt_q - 1'b1;
        if (ge && (cnt_q >= MD_CNT_W'(DEP_W))) sat_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      MD_IDLE: begin
        if (start_i) begin
          a_q <= a_i;
          b_q <= b_i;
          c_q <= c_i;
        end
      end
      MD_MUL_LO: mul_q <= mul_a * b_q;
      MD_MUL_HI: begin
        lo_q  <= mul_q;
        mul_q <= mul_a * b_q;
      end
      MD_SUM: begin
        prod_q <= {{HALF_W{1'b0}}, lo_q} + {mul_q, {HALF_W{1'b0}}};
        rem_q  <= '0;
        quo_q  <= '0;
      end
      MD_DIV: begin
        rem_q  <= ge ? diff[PC_W-1:0] : trial[PC_W-1:0];
        prod_q <= {prod_q[PROD_W-2:0], 1'b0};
        quo_q  <= {quo_q[DEP_W-2:0], ge};
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign q_o    = (c_q == '0) ? '0 : (sat_q ? DEP_MAX : quo_q);

  `BCE_ASSERT(md_start_idle, clk_i, rst_ni, start_i |-> state_q == MD_IDLE, "start while busy")
  `BCE_ASSERT(md_done_after_div, clk_i, rst_ni, done_q |-> $past(state_q) == MD_DIV, "stray done")

endmodule

[rtl/core/bce_ctrl.sv]
// ---------------------------------------------------------------------------
// bce_ctrl
// Sequencer for loads, reads and the per-source Brandes passes.
// ---------------------------------------------------------------------------
module bce_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [1:0]     in_func_i,
  input  bce_pkg::stat_t stat_i,
  output bce_pkg::cmd_t  cmd_o,
  output logic           in_ready_o
);
  import bce_pkg::*;

  st_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_BOOT:     if (stat_i.sweep_last) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_func_i == FUNC_RUN) state_d = ST_CLEAR;
          else if (in_func_i == FUNC_READ) state_d = ST_READ;
        end
      end
      ST_CLEAR:    if (stat_i.sweep_last) state_d = ST_SRC;
      ST_SRC:      state_d = stat_i.src_lt_n ? ST_INIT : ST_DONE;
      ST_INIT:     if (stat_i.init_last) state_d = ST_SEED;
      ST_SEED:     state_d = ST_B_HEAD;
      ST_B_HEAD:   state_d = stat_i.head_lt_tail ? ST_B_V1 : ST_R_TOP;
      ST_B_V1:     state_d = ST_B_V2;
      ST_B_V2:     state_d = ST_B_V3;
      ST_B_V3:     state_d = ST_B_EDGE;
      ST_B_EDGE:   state_d = stat_i.j_lt_hi ? ST_B_E1 : ST_B_HEAD;
      ST_B_E1:     state_d = stat_i.nb_bad ? ST_B_EDGE : ST_B_E2;
      ST_B_E2:     state_d = ST_B_EDGE;
      ST_R_TOP:    state_d = stat_i.k_nz ? ST_R_W1 : ST_NEXT;
      ST_R_W1:     state_d = ST_R_W2;
      ST_R_W2:     state_d = ST_R_W3;
      ST_R_W3:     state_d = stat_i.cur_is_src ? ST_R_TOP : ST_R_EDGE;
      ST_R_EDGE:   state_d = stat_i.j_lt_hi ? ST_R_E1 : ST_R_CENT;
      ST_R_E1:     state_d = stat_i.nb_bad ? ST_R_EDGE : ST_R_E2;
      ST_R_E2:     state_d = stat_i.dep_pass ? ST_R_MD : ST_R_EDGE;
      ST_R_MD:     if (stat_i.md_done) state_d = ST_R_E3;
      ST_R_E3:     state_d = ST_R_EDGE;
      ST_R_CENT:   state_d = ST_R_C2;
      ST_R_C2:     state_d = ST_R_TOP;
      ST_NEXT:     state_d = ST_SRC;
      ST_DONE:     if (stat_i.out_free) state_d = ST_IDLE;
      ST_READ:     state_d = ST_READ_OUT;
      ST_READ_OUT: if (stat_i.out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op     = OP_NONE;
    cmd_o.accept = 1'b0;
    in_ready_o   = 1'b0;
    case (state_q)
      ST_BOOT, ST_CLEAR:     cmd_o.op = OP_CLEAR;
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_INIT:               cmd_o.op = OP_INIT;
      ST_SEED:               cmd_o.op = OP_SEED;
      ST_B_HEAD:             cmd_o.op = OP_B_HEAD;
      ST_B_V1, ST_R_W1:      cmd_o.op = OP_V1;
      ST_B_V2, ST_R_W2:      cmd_o.op = OP_V2;
      ST_B_V3, ST_R_W3:      cmd_o.op = OP_V3;
      ST_B_EDGE, ST_R_EDGE:  cmd_o.op = OP_EDGE;
      ST_B_E1, ST_R_E1:      cmd_o.op = OP_E1;
      ST_B_E2:               cmd_o.op = OP_B_E2;
      ST_R_TOP:              cmd_o.op = OP_R_TOP;
      ST_R_E2:               cmd_o.op = OP_R_E2;
      ST_R_E3:               cmd_o.op = OP_R_E3;
      ST_R_CENT:             cmd_o.op = OP_R_CENT;
      ST_R_C2:               cmd_o.op = OP_R_C2;
      ST_NEXT:               cmd_o.op = OP_NEXT;
      ST_DONE:               cmd_o.op = OP_DONE;
      ST_READ:               cmd_o.op = OP_READ;
      ST_READ_OUT:           cmd_o.op = OP_READ_OUT;
      default:               cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_BOOT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/core/bce_dp.sv]
// ---------------------------------------------------------------------------
// bce_dp
// Graph, search and score memories with the registers that walk them.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bce_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bce_pkg::cmd_t               cmd_i,
  output bce_pkg::stat_t              stat_o,
  input  bce_pkg::in_item_t           in_item_i,
  input  logic                        cfg_we_i,
  input  logic [bce_pkg::VCNT_W-1:0]  cfg_wdata_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output bce_pkg::out_item_t          out_item_o
);
  import bce_pkg::*;

  logic [ROW_W-1:0]   rs_mem   [MaxVertices+1];
  logic [NB_W-1:0]    nb_mem   [MaxEdgeEntries];
  logic [DIST_W-1:0]  dist_mem [MaxVertices];
  logic [PC_W-1:0]    pc_mem   [MaxVertices];
  logic [DEP_W-1:0]   dep_mem  [MaxVertices];
  logic [VIDX_W-1:0]  vo_mem   [MaxVertices];
  logic [SCORE_W-1:0] cent_mem [MaxVertices];

  logic [ROW_W-1:0]   rs_rd_q;
  logic [NB_W-1:0]    nb_rd_q;
  logic [DIST_W-1:0]  dist_rd_q;
  logic [PC_W-1:0]    pc_rd_q;
  logic [DEP_W-1:0]   dep_rd_q;
  logic [VIDX_W-1:0]  vo_rd_q;
  logic [SCORE_W-1:0] cent_rd_q;

  logic [VIDX_W-1:0] idx_q;
  logic [VCNT_W-1:0] vcount_q, n_q, src_q, head_q, tail_q, k_q;
  logic              wrap_q;
  logic              out_valid_q;

  logic [VIDX_W-1:0]  cur_q, nbr_q;
  logic [ROW_W-1:0]   lo_q, hi_q, j_q;
  logic [DIST_W-1:0]  cur_dist_q;
  logic [PC_W-1:0]    cur_pc_q;
  logic [DEP_W-1:0]   cur_dep_q, nbr_dep_q;
  logic [ROW_W-1:0]   rd_idx_q;
  logic [SCORE_W-1:0] rd_score_q;
  out_item_t          out_item_q;

  logic [VCNT_W-1:0]  rs_ra;
  logic [VIDX_W-1:0]  vx_ra, vo_ra, cent_ra;
  logic [VCNT_W-1:0]  k_m1;
  logic [ROW_W-1:0]   hi_c, lo_c;
  logic [DIST_W-1:0]  nd;
  logic               visit, bump;
  logic [PC_W:0]      psum;
  logic [DEP_W:0]     dsum;
  logic [DEP_W-1:0]   dnew;
  logic [SCORE_W:0]   csum;
  logic [SCORE_W-1:0] cnew;
  logic [VCNT_W-1:0]  n_c;
  logic               out_free, out_load;
  logic               md_start, md_done;
  logic [DEP_W-1:0]   md_q;
  logic [MB_W-1:0]    md_b;

  logic               dist_we, pc_we, dep_we, vo_we, cent_we;
  logic [VIDX_W-1:0]  dist_wa, pc_wa, dep_wa, vo_wa, cent_wa;
  logic [DIST_W-1:0]  dist_wd;
  logic [PC_W-1:0]    pc_wd;
  logic [DEP_W-1:0]   dep_wd;
  logic [VIDX_W-1:0]  vo_wd;
  logic [SCORE_W-1:0] cent_wd;
  op_e                op;

  assign op   = cmd_i.op;
  assign k_m1 = k_q - 1'b1;
  assign n_c  = (vcount_q > VCNT_W'(MaxVertices)) ? VCNT_W'(MaxVertices) : vcount_q;

  assign hi_c  = (rs_rd_q > ROW_W'(MaxEdgeEntries)) ? ROW_W'(MaxEdgeEntries) : rs_rd_q;
  assign lo_c  = (lo_q > hi_c) ? hi_c : lo_q;
  assign nd    = cur_dist_q + DIST_W'(1);
  assign visit = (dist_rd_q == DIST_UNV) && (tail_q < n_q);
  assign bump  = (visit ? nd : dist_rd_q) == nd;
  assign psum  = {1'b0, pc_rd_q} + {1'b0, cur_pc_q};
  assign dsum  = {1'b0, nbr_dep_q} + {1'b0, md_q};
  assign dnew  = dsum[DEP_W] ? DEP_MAX : dsum[DEP_W-1:0];
  assign csum  = {1'b0, cent_rd_q} + (SCORE_W+1)'(cur_dep_q);
  assign cnew  = csum[SCORE_W] ? SCORE_MAX : csum[SCORE_W-1:0];
  assign md_b  = MB_W'(1 << FractionBits) + {1'b0, cur_dep_q};

  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = out_free && (op == OP_DONE || op == OP_READ_OUT);

  always_comb begin
    stat_o.sweep_last   = idx_q == VIDX_W'(MaxVertices - 1);
    stat_o.init_last    = {1'b0, idx_q} == (n_q - 1'b1);
    stat_o.src_lt_n     = src_q < n_q;
    stat_o.head_lt_tail = head_q < tail_q;
    stat_o.j_lt_hi      = j_q < hi_q;
    stat_o.nb_bad       = nb_rd_q[NB_W-1] || ({1'b0, nb_rd_q[VIDX_W-1:0]} >= n_q);
    stat_o.k_nz         = k_q != '0;
    stat_o.cur_is_src   = cur_dist_q == '0;
    stat_o.dep_pass     = (dist_rd_q != DIST_UNV) && ((dist_rd_q + DIST_W'(1)) == cur_dist_q);
    stat_o.md_done      = md_done;
    stat_o.out_free     = out_free;
  end

  assign md_start = (op == OP_R_E2) && stat_o.dep_pass;

  bce_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .a_i     (pc_rd_q),
    .b_i     (md_b),
    .c_i     (cur_pc_q),
    .done_o  (md_done),
    .q_o     (md_q)
  );

  always_comb begin
    rs_ra   = {1'b0, cur_q} + VCNT_W'(1);
    vx_ra   = cur_q;
    vo_ra   = head_q[VIDX_W-1:0];
    cent_ra = in_item_i.index[VIDX_W-1:0];
    case (op)
      OP_V1: begin
        rs_ra = {1'b0, vo_rd_q};
        vx_ra = vo_rd_q;
      end
      OP_E1:     vx_ra   = nb_rd_q[VIDX_W-1:0];
      OP_R_TOP:  vo_ra   = k_m1[VIDX_W-1:0];
      OP_R_CENT: cent_ra = cur_q;
      default: ;
    endcase
  end

  always_comb begin
    dist_we = 1'b0; dist_wa = idx_q;   dist_wd = DIST_UNV;
    pc_we   = 1'b0; pc_wa   = idx_q;   pc_wd   = '0;
    dep_we  = 1'b0; dep_wa  = idx_q;   dep_wd  = '0;
    vo_we   = 1'b0; vo_wa   = tail_q[VIDX_W-1:0]; vo_wd = nbr_q;
    cent_we = 1'b0; cent_wa = idx_q;   cent_wd = '0;
    case (op)
      OP_CLEAR: cent_we = 1'b1;
      OP_INIT: begin
        dist_we = 1'b1;
        pc_we   = 1'b1;
        dep_we  = 1'b1;
      end
      OP_SEED: begin
        dist_we = 1'b1; dist_wa = src_q[VIDX_W-1:0]; dist_wd = '0;
        pc_we   = 1'b1; pc_wa   = src_q[VIDX_W-1:0]; pc_wd   = PC_W'(1);
        vo_we   = 1'b1; vo_wa   = '0;                vo_wd   = src_q[VIDX_W-1:0];
      end
      OP_B_E2: begin
        dist_we = visit; dist_wa = nbr_q; dist_wd = nd;
        vo_we   = visit;
        pc_we   = bump;  pc_wa   = nbr_q; pc_wd   = psum[PC_W-1:0];
      end
      OP_R_E3: begin
        dep_we = 1'b1; dep_wa = nbr_q; dep_wd = dnew;
      end
      OP_R_C2: begin
        cent_we = 1'b1; cent_wa = cur_q; cent_wd = cnew;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rs_rd_q   <= rs_mem[rs_ra];
    nb_rd_q   <= nb_mem[j_q[EIDX_W-1:0]];
    dist_rd_q <= dist_mem[vx_ra];
    pc_rd_q   <= pc_mem[vx_ra];
    dep_rd_q  <= dep_mem[vx_ra];
    vo_rd_q   <= vo_mem[vo_ra];
    cent_rd_q <= cent_mem[cent_ra];
    if (cmd_i.accept && in_item_i.func == FUNC_ROW && in_item_i.index <= ROW_W'(MaxVertices)) begin
      rs_mem[in_item_i.index[VCNT_W-1:0]] <= in_item_i.value;
    end
    if (cmd_i.accept && in_item_i.func == FUNC_COL &&
        in_item_i.index < ROW_W'(MaxEdgeEntries)) begin
      nb_mem[in_item_i.index[EIDX_W-1:0]] <=
        {in_item_i.value >= ROW_W'(MaxVertices), in_item_i.value[VIDX_W-1:0]};
    end
    if (dist_we) dist_mem[dist_wa] <= dist_wd;
    if (pc_we)   pc_mem[pc_wa]     <= pc_wd;
    if (dep_we)  dep_mem[dep_wa]   <= dep_wd;
    if (vo_we)   vo_mem[vo_wa]     <= vo_wd;
    if (cent_we) cent_mem[cent_wa] <= cent_wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      vcount_q    <= VCNT_W'(1);
      n_q         <= VCNT_W'(1);
      src_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      k_q         <= '0;
      wrap_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) vcount_q <= cfg_wdata_i;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (op)
        OP_CLEAR: idx_q <= stat_o.sweep_last ? '0 : idx_q + 1'b1;
        OP_INIT:  idx_q <= stat_o.init_last ? '0 : idx_q + 1'b1;
        OP_SEED: begin
          head_q <= '0;
          tail_q <= VCNT_W'(1);
        end
        OP_B_HEAD: begin
          if (stat_o.head_lt_tail) head_q <= head_q + 1'b1;
          else k_q <= tail_q;
        end
        OP_B_E2: begin
          if (visit) tail_q <= tail_q + 1'b1;
          if (bump && psum[PC_W]) wrap_q <= 1'b1;
        end
        OP_R_TOP: if (stat_o.k_nz) k_q <= k_m1;
        OP_NEXT:  src_q <= src_q + 1'b1;
        default: ;
      endcase
      if (cmd_i.accept && in_item_i.func == FUNC_RUN) begin
        n_q    <= n_c;
        wrap_q <= 1'b0;
        src_q  <= '0;
        head_q <= '0;
        tail_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) rd_idx_q <= in_item_i.index;
    case (op)
      OP_V1: cur_q <= vo_rd_q;
      OP_V2: begin
        lo_q       <= rs_rd_q;
        cur_dist_q <= dist_rd_q;
        cur_pc_q   <= pc_rd_q;
        cur_dep_q  <= dep_rd_q;
      end
      OP_V3: begin
        j_q  <= lo_c;
        hi_q <= hi_c;
      end
      OP_EDGE: if (stat_o.j_lt_hi) j_q <= j_q + 1'b1;
      OP_E1:   nbr_q <= nb_rd_q[VIDX_W-1:0];
      OP_R_E2: nbr_dep_q <= dep_rd_q;
      OP_READ: rd_score_q <= (rd_idx_q < ROW_W'(MaxVertices)) ? cent_rd_q : '0;
      default: ;
    endcase
    if (out_load) begin
      if (op == OP_READ_OUT) begin
        out_item_q.kind   <= KIND_SCORE;
        out_item_q.vertex <= rd_idx_q[VIDX_W-1:0];
        out_item_q.score  <= rd_score_q;
      end else begin
        out_item_q.kind   <= KIND_DONE;
        out_item_q.vertex <= '0;
        out_item_q.score  <= '0;
      end
      out_item_q.overflow <= wrap_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `BCE_ASSERT(dp_head_le_tail, clk_i, rst_ni, head_q <= tail_q, "queue head passed tail")
  `BCE_ASSERT_NEVER(dp_tail_over_n, clk_i, rst_ni, tail_q > n_q, "more vertices queued than in use")
  `BCE_ASSERT(dp_k_le_tail, clk_i, rst_ni, k_q <= tail_q, "reverse index beyond queue")

endmodule

[rtl/core/betweenness_centrality_engine.sv]
// ---------------------------------------------------------------------------
// betweenness_centrality_engine
// Brandes betweenness centrality over a graph loaded in compressed-row form.
// ---------------------------------------------------------------------------
//  channel  direction  handshake                payload
//  in       input      in_valid_i / in_ready_o  in_item_i  (func, index, value)
//  out      output     out_valid_o / out_ready_i out_item_o (kind, vertex, score, overflow)
//  cfg      input      cfg_we_i                 cfg_wdata_i (vertex_count)
//
//  Row and column loads write memory directly; a score read is fetched and
//  registered, then sent. A run clears the scores, then per source sets up
//  n vertices, seeds the source, walks visited vertices and their edges in
//  a forward and a reverse pass, and waits on the bit-serial divider per
//  dependency term. After reset the scores are cleared; no item is taken.
//  Input is held off while a run or read is in progress or its result waits.
// ---------------------------------------------------------------------------
module betweenness_centrality_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  bce_pkg::in_item_t            in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output bce_pkg::out_item_t           out_item_o,
  input  logic                         cfg_we_i,
  input  logic [bce_pkg::VCNT_W-1:0]   cfg_wdata_i
);
  import bce_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_func_i  (in_item_i.func),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_ready_o (in_ready_o)
  );

  bce_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule
